// File: src/biquad_iir_filter_core_assert.svh
// assertion macros for the biquad filter core
// no dependencies; included by the top level only
`ifndef BIQUAD_IIR_FILTER_CORE_ASSERT_SVH
`define BIQUAD_IIR_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define BQF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on the rising clock edge outside reset
`define BQF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/bqf_pkg.sv
// shared types and constants of the biquad filter core
// no dependencies; used by the interfaces and every module
`default_nettype none

package bqf_pkg;

   // sample and coefficient formats
   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_WIDTH     = 20;
   localparam int COEF_FRAC_BITS = 16;

   // feed-forward taps: current input and two inputs back
   localparam int NUM_TAPS = 3;

   // product and accumulator widths, with headroom for five products
   localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + 3;

   // register file
   localparam int NUM_CSR         = 5;
   localparam int CSR_INDEX_WIDTH = $clog2(NUM_CSR);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_B0,
      CSR_B1,
      CSR_B2,
      CSR_A1,
      CSR_A2
   } csr_index_type;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [COEF_WIDTH-1:0]   coef_type;
   typedef logic signed [PROD_WIDTH-1:0]   prod_type;
   typedef logic signed [ACC_WIDTH-1:0]    acc_type;

   // unity gain in coefficient format
   localparam coef_type COEF_ONE = COEF_WIDTH'(1) << COEF_FRAC_BITS;

   // control of one tap cell
   typedef struct packed {
      logic shift;   // take the neighbour's sample into the history
      logic mult;    // capture the product of the held sample
   } cell_ctrl_type;

   // control of the feedback stage
   typedef struct packed {
      logic load;    // feed-forward sum moves into the output register
      logic take;    // result transfer on the output channel
   } fb_ctrl_type;

   // feed-forward sum travelling into the feedback stage
   typedef struct packed {
      acc_type acc;
      logic    block_end;
   } ff_item_type;

   // finished result held in the output register
   typedef struct packed {
      sample_type sample;
      logic       clipped;
      logic       block_end;
   } result_type;

endpackage

`default_nettype wire

// File: src/bqf_chan_if.sv
// valid/ready channels of the biquad filter core: sample request and result
// depends on bqf_pkg
`default_nettype none

interface bqf_req_if;
   import bqf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_in;
   logic       block_end;

   modport source (output valid, output sample_in, output block_end, input ready);
   modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface bqf_rsp_if;
   import bqf_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_out;
   logic       clipped;
   logic       block_end_out;

   modport source (output valid, output sample_out, output clipped, output block_end_out,
                   input ready);
   modport sink   (input valid, input sample_out, input clipped, input block_end_out,
                   output ready);
endinterface

`default_nettype wire

// File: src/bqf_tap_cell.sv
// one feed-forward tap cell: a history sample and its registered product
// depends on bqf_pkg
`default_nettype none

module bqf_tap_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  bqf_pkg::cell_ctrl_type ctrl,
   input  bqf_pkg::coef_type      coef,
   input  bqf_pkg::sample_type    sample_in,
   output bqf_pkg::sample_type    hist_out,
   output bqf_pkg::prod_type      prod_out
);
   import bqf_pkg::*;

   sample_type hist_ff, hist_in;
   prod_type   prod_ff, prod_in;

   // history shifts along the row on every input transfer
   always_comb begin
      hist_in = ctrl.shift ? sample_in : hist_ff;
   end

   // tap product of the held sample
   always_comb begin
      prod_in = ctrl.mult ? PROD_WIDTH'(coef) * PROD_WIDTH'(hist_ff) : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else begin
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign hist_out = hist_ff;
   assign prod_out = prod_ff;

endmodule

`default_nettype wire

// File: src/bqf_fb_stage.sv
// feedback stage: output history, feedback products, rounding, saturation
// and the output register; depends on bqf_pkg
`default_nettype none

module bqf_fb_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  bqf_pkg::fb_ctrl_type ctrl,
   input  bqf_pkg::ff_item_type item,
   input  bqf_pkg::coef_type    coef_a1,
   input  bqf_pkg::coef_type    coef_a2,
   output logic                 valid,
   output bqf_pkg::result_type  result
);
   import bqf_pkg::*;

   localparam acc_type ROUND_BIAS = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
   localparam acc_type SAT_MAX =
      {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam acc_type SAT_MIN =
      {{(ACC_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   sample_type y1_ff, y1_in;
   sample_type y2_ff, y2_in;
   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   prod_type   fb1;
   prod_type   fb2;
   acc_type    total;
   acc_type    scaled;
   sample_type y_next;
   logic       clip_next;

   // feedback products from the two previous outputs
   always_comb begin
      fb1 = PROD_WIDTH'(coef_a1) * PROD_WIDTH'(y1_ff);
      fb2 = PROD_WIDTH'(coef_a2) * PROD_WIDTH'(y2_ff);
   end

   // round to nearest, ties upwards, then clamp to the sample range
   always_comb begin
      total  = item.acc - ACC_WIDTH'(fb1) - ACC_WIDTH'(fb2) + ROUND_BIAS;
      scaled = total >>> COEF_FRAC_BITS;
      if (scaled > SAT_MAX) begin
         y_next    = SAT_MAX[SAMPLE_WIDTH-1:0];
         clip_next = 1'b1;
      end else if (scaled < SAT_MIN) begin
         y_next    = SAT_MIN[SAMPLE_WIDTH-1:0];
         clip_next = 1'b1;
      end else begin
         y_next    = scaled[SAMPLE_WIDTH-1:0];
         clip_next = 1'b0;
      end
   end

   // history and output register advance together
   always_comb begin
      y1_in     = y1_ff;
      y2_in     = y2_ff;
      result_in = result_ff;
      valid_in  = valid_ff & ~ctrl.take;
      if (ctrl.load) begin
         y1_in            = y_next;
         y2_in            = y1_ff;
         result_in.sample    = y_next;
         result_in.clipped   = clip_next;
         result_in.block_end = item.block_end;
         valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y1_ff    <= '0;
         y2_ff    <= '0;
         valid_ff <= 1'b0;
      end else begin
         y1_ff    <= y1_in;
         y2_ff    <= y2_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign valid  = valid_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// File: src/biquad_iir_filter_core.sv
// top level of the biquad filter core: coefficient registers, tap cell row,
// feed-forward sum and feedback stage; depends on bqf_pkg, bqf_chan_if,
// bqf_tap_cell, bqf_fb_stage and the assertion macro header
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    sample_in, block_end
//   rsp_chan  out        valid / ready    sample_out, clipped, block_end_out
//   csr_*     in         csr_wr_en only   csr_index, csr_wdata
//
// one sample per clock while the output is not stalled
// the rate is set by the feedback stage: combinational a1*y1 multiply, add, round, clamp
// synchronous reset restores unity gain and clears all input and output history
// a stalled output fills the four stages, after which req_chan.ready drops
`default_nettype none
`include "biquad_iir_filter_core_assert.svh"

module biquad_iir_filter_core (
   input  logic                                clock,
   input  logic                                reset,
   bqf_req_if.sink                             req_chan,
   bqf_rsp_if.source                           rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [bqf_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  bqf_pkg::coef_type                   csr_wdata
);
   import bqf_pkg::*;

   // coefficient registers
   coef_type ff_coef_ff [NUM_TAPS];
   coef_type ff_coef_in [NUM_TAPS];
   coef_type a1_ff, a1_in;
   coef_type a2_ff, a2_in;

   // stage valid bits and block markers
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic be1_ff, be1_in;
   logic be2_ff, be2_in;
   logic be3_ff, be3_in;

   // feed-forward sum register
   acc_type ff_sum_ff, ff_sum_in;
   acc_type ff_sum;

   // stage moves
   logic req_xfer;
   logic rsp_xfer;
   logic adv2, adv3, adv4;
   logic s1_free, s2_free, s3_free;

   cell_ctrl_type cell_ctrl;
   fb_ctrl_type   fb_ctrl;
   ff_item_type   fb_item;
   result_type    fb_result;
   logic          fb_valid;

   sample_type tap_link [NUM_TAPS];
   prod_type   tap_prod [NUM_TAPS];

   // register writes
   always_comb begin
      ff_coef_in = ff_coef_ff;
      a1_in      = a1_ff;
      a2_in      = a2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_B0:  ff_coef_in[0] = csr_wdata;
            CSR_B1:  ff_coef_in[1] = csr_wdata;
            CSR_B2:  ff_coef_in[2] = csr_wdata;
            CSR_A1:  a1_in         = csr_wdata;
            CSR_A2:  a2_in         = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ff_coef_ff[0] <= COEF_ONE;
         ff_coef_ff[1] <= '0;
         ff_coef_ff[2] <= '0;
         a1_ff         <= '0;
         a2_ff         <= '0;
      end else begin
         ff_coef_ff <= ff_coef_in;
         a1_ff      <= a1_in;
         a2_ff      <= a2_in;
      end
   end

   // elastic stage control, bubbles collapse towards the output
   always_comb begin
      rsp_xfer = rsp_chan.valid & rsp_chan.ready;
      adv4     = v3_ff & (~fb_valid | rsp_chan.ready);
      s3_free  = ~v3_ff | adv4;
      adv3     = v2_ff & s3_free;
      s2_free  = ~v2_ff | adv3;
      adv2     = v1_ff & s2_free;
      s1_free  = ~v1_ff | adv2;
      req_xfer = req_chan.valid & s1_free;
   end

   assign req_chan.ready = s1_free;

   always_comb begin
      v1_in  = req_xfer | (v1_ff & ~adv2);
      v2_in  = adv2 | (v2_ff & ~adv3);
      v3_in  = adv3 | (v3_ff & ~adv4);
      be1_in = req_xfer ? req_chan.block_end : be1_ff;
      be2_in = adv2 ? be1_ff : be2_ff;
      be3_in = adv3 ? be2_ff : be3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      be1_ff <= be1_in;
      be2_ff <= be2_in;
      be3_ff <= be3_in;
   end

   // row of tap cells: the input sample enters the first cell
   always_comb begin
      cell_ctrl.shift = req_xfer;
      cell_ctrl.mult  = adv2;
   end

   assign tap_link[0] = req_chan.sample_in;

   for (genvar k = 0; k < NUM_TAPS; k++) begin : g_tap
      if (k == NUM_TAPS - 1) begin : g_last
         bqf_tap_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .coef      (ff_coef_ff[k]),
            .sample_in (tap_link[k]),
            .hist_out  (),
            .prod_out  (tap_prod[k])
         );
      end else begin : g_mid
         bqf_tap_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (cell_ctrl),
            .coef      (ff_coef_ff[k]),
            .sample_in (tap_link[k]),
            .hist_out  (tap_link[k+1]),
            .prod_out  (tap_prod[k])
         );
      end
   end

   // feed-forward sum of the tap products
   always_comb begin
      ff_sum = '0;
      for (int k = 0; k < NUM_TAPS; k++) begin
         ff_sum = ff_sum + ACC_WIDTH'(tap_prod[k]);
      end
      ff_sum_in = adv3 ? ff_sum : ff_sum_ff;
   end

   always_ff @(posedge clock) begin
      ff_sum_ff <= ff_sum_in;
   end

   // feedback stage and output register
   always_comb begin
      fb_ctrl.load      = adv4;
      fb_ctrl.take      = rsp_xfer;
      fb_item.acc       = ff_sum_ff;
      fb_item.block_end = be3_ff;
   end

   bqf_fb_stage u_fb (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (fb_ctrl),
      .item    (fb_item),
      .coef_a1 (a1_ff),
      .coef_a2 (a2_ff),
      .valid   (fb_valid),
      .result  (fb_result)
   );

   assign rsp_chan.valid         = fb_valid;
   assign rsp_chan.sample_out    = fb_result.sample;
   assign rsp_chan.clipped       = fb_result.clipped;
   assign rsp_chan.block_end_out = fb_result.block_end;

   // an empty output register never holds back the input side
   `BQF_ASSERT_IMP(a_ready_when_out_empty, clock, reset, !rsp_chan.valid, req_chan.ready,
                   "input stalled with an empty output register")

   // a clipped result sits exactly on one of the range bounds
   `BQF_ASSERT_IMP(a_clip_at_bound, clock, reset, rsp_chan.valid && rsp_chan.clipped,
                   (rsp_chan.sample_out == {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}}) ||
                   (rsp_chan.sample_out == {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}}),
                   "clipped result not at a range bound")

   // a result transfer with nothing behind it leaves the output empty
   `BQF_ASSERT_NXT(a_no_phantom_result, clock, reset, rsp_xfer && !v3_ff, !rsp_chan.valid,
                   "result appeared with no sum behind it")

endmodule

`default_nettype wire
